@@ sv/abmx_pkg.sv @@
// Package for the 3x3 absolute-maximum window filter.
// Holds the widths, register indexes, word and window types and the magnitude helper.
// No dependencies; every other file refers to it by scoped names.
package abmx_pkg;

  // Sizes of the line memory, pixels and counters.
  localparam int MAX_WIDTH  = 1024;
  localparam int PIX_W      = 16;
  localparam int COL_W      = 10;
  localparam int WID_W      = 11;
  localparam int ROW_W      = 16;
  localparam int MAG_W      = PIX_W + 1;
  localparam int WIN_N      = 9;
  localparam int CENTRE     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Register values after reset.
  localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd512;
  localparam logic [ROW_W-1:0] HEIGHT_RESET = 16'd512;

  typedef logic signed [PIX_W-1:0] pix_t;
  typedef logic [MAG_W-1:0]        mag_t;

  // Input and result words.
  typedef struct packed {
    pix_t pixel_value;
    logic flush;
  } in_word_t;

  typedef struct packed {
    pix_t filtered_pixel;
    logic frame_last;
  } out_word_t;

  // Position information that travels with a word into the window stage.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             feed;
    logic             emit;
    logic             lclamp;
    logic             rclamp;
    logic             tclamp;
    logic             bclamp;
  } pos_ctl_t;

  // One window column: rows above, at and below the centre row.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_vec_t;

  // Window in scan order: top row left to right, then middle, then bottom.
  typedef pix_t [WIN_N-1:0] win_t;

  // True magnitude of a signed pixel, one bit wider so the most negative value fits.
  function automatic mag_t pix_mag(pix_t v);
    logic [MAG_W-1:0] ext;
    ext = {v[PIX_W-1], v};
    return ext[MAG_W-1] ? (~ext + MAG_W'(1)) : ext;
  endfunction

endpackage

@@ sv/abmx_window.sv @@
// Line memory and window stage of the 3x3 absolute-maximum filter.
// Keeps the two previous rows per column in one memory and builds the clamped window.
// Depends on abmx_pkg.
module abmx_window (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        step,
  input  abmx_pkg::pos_ctl_t          step_ctl,
  input  abmx_pkg::pix_t              step_pix,
  output logic                        win_valid,
  output abmx_pkg::win_t              win,
  output logic                        win_last
);

  localparam int MEM_W = 2 * abmx_pkg::PIX_W;

  // Each entry holds the two latest rows of its column: {older, newer}.
  logic [MEM_W-1:0]     mem [abmx_pkg::MAX_WIDTH];
  logic [MEM_W-1:0]     rd_data_r;
  logic [MEM_W-1:0]     fwd_data_r;
  logic                 fwd_r;
  logic                 fwd_nxt;

  logic                 s1_valid_r;
  abmx_pkg::pos_ctl_t   s1_ctl_r;
  abmx_pkg::pix_t       s1_pix_r;

  abmx_pkg::col_vec_t   a_r;
  abmx_pkg::col_vec_t   b_r;
  abmx_pkg::col_vec_t   n_vec;
  abmx_pkg::col_vec_t   l_vec;
  abmx_pkg::col_vec_t   r_vec;
  abmx_pkg::col_vec_t   lc;
  abmx_pkg::col_vec_t   cc;
  abmx_pkg::col_vec_t   rc;

  logic [MEM_W-1:0]     rd_word;
  logic [MEM_W-1:0]     wr_data;
  logic                 wr_en;

  logic                 win_valid_r;
  abmx_pkg::win_t       win_r;
  abmx_pkg::win_t       win_nxt;
  logic                 win_last_r;

  // Replace rows that fall outside the image by the centre row.
  function automatic abmx_pkg::col_vec_t clamp_rows(abmx_pkg::col_vec_t v, logic t, logic b);
    abmx_pkg::col_vec_t o;
    o.top = t ? v.mid : v.top;
    o.mid = v.mid;
    o.bot = b ? v.mid : v.bot;
    return o;
  endfunction

  // Read port on accept, write-back of the shifted column from the window stage.
  always_ff @(posedge clk) begin
    if (step) begin
      rd_data_r <= mem[step_ctl.col];
    end
    if (wr_en) begin
      mem[s1_ctl_r.col] <= wr_data;
    end
  end

  // A write and a read of the same column at one edge only happen when the row is one
  // pixel wide; the written word is then forwarded.
  assign wr_en   = adv && s1_valid_r && s1_ctl_r.feed;
  assign fwd_nxt = step && wr_en && (step_ctl.col == s1_ctl_r.col);

  // Column vector of the word in the window stage.
  always_comb begin
    rd_word   = fwd_r ? fwd_data_r : rd_data_r;
    n_vec.top = rd_word[MEM_W-1:abmx_pkg::PIX_W];
    n_vec.mid = rd_word[abmx_pkg::PIX_W-1:0];
    n_vec.bot = s1_pix_r;
    wr_data   = {n_vec.mid, s1_pix_r};
  end

  // Window with the left and right columns clamped at the image edges.
  always_comb begin
    l_vec = s1_ctl_r.lclamp ? b_r : a_r;
    r_vec = s1_ctl_r.rclamp ? b_r : n_vec;
    lc    = clamp_rows(l_vec, s1_ctl_r.tclamp, s1_ctl_r.bclamp);
    cc    = clamp_rows(b_r,   s1_ctl_r.tclamp, s1_ctl_r.bclamp);
    rc    = clamp_rows(r_vec, s1_ctl_r.tclamp, s1_ctl_r.bclamp);
    win_nxt[0] = lc.top;
    win_nxt[1] = cc.top;
    win_nxt[2] = rc.top;
    win_nxt[3] = lc.mid;
    win_nxt[4] = cc.mid;
    win_nxt[5] = rc.mid;
    win_nxt[6] = lc.bot;
    win_nxt[7] = cc.bot;
    win_nxt[8] = rc.bot;
  end

  // Control state of the stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      win_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= step;
      fwd_r       <= fwd_nxt;
      win_valid_r <= s1_valid_r && s1_ctl_r.emit;
    end
  end

  // Stage payload and the two older window columns.
  always_ff @(posedge clk) begin
    if (step) begin
      s1_ctl_r <= step_ctl;
      s1_pix_r <= step_pix;
    end
    if (adv) begin
      fwd_data_r <= wr_data;
    end
    if (adv && s1_valid_r) begin
      a_r        <= b_r;
      b_r        <= n_vec;
      win_r      <= win_nxt;
      win_last_r <= s1_ctl_r.rclamp && s1_ctl_r.bclamp;
    end
  end

  assign win_valid = win_valid_r;
  assign win       = win_r;
  assign win_last  = win_last_r;

endmodule

@@ sv/abmx_pick.sv @@
// Selection stage of the 3x3 absolute-maximum filter.
// Finds the largest magnitude, then picks the centre or the first window value reaching it.
// Depends on abmx_pkg.
module abmx_pick (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                win_valid,
  input  abmx_pkg::win_t      win,
  input  logic                win_last,
  output logic                res_valid,
  output abmx_pkg::out_word_t res
);

  abmx_pkg::mag_t m [abmx_pkg::WIN_N];
  abmx_pkg::mag_t mx01, mx23, mx45, mx67, mx03, mx47, mx07, mx_all;

  logic           pk_valid_r;
  abmx_pkg::mag_t mags_r [abmx_pkg::WIN_N];
  abmx_pkg::win_t vals_r;
  abmx_pkg::mag_t max_r;
  logic           last_r;
  abmx_pkg::pix_t sel;

  function automatic abmx_pkg::mag_t max2(abmx_pkg::mag_t x, abmx_pkg::mag_t y);
    return (x > y) ? x : y;
  endfunction

  // Magnitudes and a balanced maximum tree.
  always_comb begin
    for (int i = 0; i < abmx_pkg::WIN_N; i++) begin
      m[i] = abmx_pkg::pix_mag(win[i]);
    end
    mx01   = max2(m[0], m[1]);
    mx23   = max2(m[2], m[3]);
    mx45   = max2(m[4], m[5]);
    mx67   = max2(m[6], m[7]);
    mx03   = max2(mx01, mx23);
    mx47   = max2(mx45, mx67);
    mx07   = max2(mx03, mx47);
    mx_all = max2(mx07, m[8]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pk_valid_r <= 1'b0;
    end else if (adv) begin
      pk_valid_r <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && win_valid) begin
      for (int i = 0; i < abmx_pkg::WIN_N; i++) begin
        mags_r[i] <= m[i];
      end
      vals_r <= win;
      max_r  <= mx_all;
      last_r <= win_last;
    end
  end

  // The centre keeps the result on a tie; otherwise the earliest value in scan order wins.
  always_comb begin
    sel = vals_r[abmx_pkg::CENTRE];
    if (mags_r[abmx_pkg::CENTRE] != max_r) begin
      for (int i = abmx_pkg::WIN_N - 1; i >= 0; i--) begin
        if (mags_r[i] == max_r) begin
          sel = vals_r[i];
        end
      end
    end
  end

  assign res_valid          = pk_valid_r;
  assign res.filtered_pixel = sel;
  assign res.frame_last     = last_r;

endmodule

@@ sv/abs_max_window_filter_3x3.sv @@
// Top level of the 3x3 absolute-maximum window filter.
// Holds configuration, raster position counters and the output register with skid word.
// Depends on abmx_pkg, abmx_window and abmx_pick.
//
// Usage: pixels enter in raster order on the in_ channel, one word per item; the
// flush bit marks a dummy word. For every image position the block returns the
// window value of largest magnitude over its 3x3 neighbourhood, with borders
// clamped to the nearest edge pixel. The result for position m is caused by input
// word m + width + 1, so after the last pixel width + 1 flush words drain the frame;
// frame_last marks the final result, after which a new frame starts. Flush words
// sent while pixels are still expected are taken and dropped.
// Path: a result is built from the line-memory read of the word that causes it,
// passes the window stage, the selection stage and the output register, to out_valid.
// Throughput: one word per cycle while in_stall is low, set by the line memory's single
// read and write port; it is read on accept and written back from the window stage.
// Reset: width and height return to 512, all counters clear; the line memory is not
// cleared, since border clamping never reads rows from an earlier frame.
// Stall: results wait in an output register backed by one skid word; in_stall rises
// while the skid word is held, and the whole pipeline then holds.
// Configuration writes (cfg_ready is always high) restart the frame; the user must make
// them while the block is idle, as the block itself does not enforce this.
module abs_max_window_filter_3x3 (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  abmx_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output abmx_pkg::out_word_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [abmx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [abmx_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [abmx_pkg::WID_W-1:0] width_r, width_nxt;
  logic [abmx_pkg::ROW_W-1:0] height_r, height_nxt;
  logic [abmx_pkg::COL_W-1:0] col_r, col_nxt;
  logic [abmx_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [abmx_pkg::WID_W-1:0] lead_r, lead_nxt;
  logic [abmx_pkg::COL_W-1:0] ocol_r, ocol_nxt;
  logic [abmx_pkg::ROW_W-1:0] orow_r, orow_nxt;

  logic [abmx_pkg::WID_W-1:0] w_eff;
  logic [abmx_pkg::COL_W-1:0] w_m1;
  logic [abmx_pkg::ROW_W-1:0] h_m1;
  logic                       feeding;
  logic                       adv;
  logic                       accept;
  logic                       step;
  logic                       emit;
  logic                       cfg_wr;
  abmx_pkg::pos_ctl_t         ctl;

  logic                       win_valid;
  abmx_pkg::win_t             win;
  logic                       win_last;
  logic                       res_valid;
  abmx_pkg::out_word_t        res;
  logic                       push;
  logic                       out_take;

  logic                       out_valid_r, out_valid_nxt;
  abmx_pkg::out_word_t        out_word_r, out_word_nxt;
  logic                       skid_valid_r, skid_valid_nxt;
  abmx_pkg::out_word_t        skid_word_r, skid_word_nxt;

  // Effective image size: a zero width or height acts as one, wide rows are capped.
  always_comb begin
    if (width_r == '0) begin
      w_eff = abmx_pkg::WID_W'(1);
    end else if (width_r > abmx_pkg::WID_W'(abmx_pkg::MAX_WIDTH)) begin
      w_eff = abmx_pkg::WID_W'(abmx_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    w_m1 = abmx_pkg::COL_W'(w_eff - abmx_pkg::WID_W'(1));
    h_m1 = (height_r == '0) ? '0 : height_r - abmx_pkg::ROW_W'(1);
  end

  // Handshakes.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;
  assign adv       = !skid_valid_r;
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && adv;
  assign feeding   = row_r <= h_m1;
  assign step      = accept && !(feeding && in_data.flush);
  assign emit      = lead_r == abmx_pkg::WID_W'(w_eff + abmx_pkg::WID_W'(1));

  // Position of the word and of the result it may cause.
  always_comb begin
    ctl.col    = col_r;
    ctl.feed   = feeding;
    ctl.emit   = emit;
    ctl.lclamp = ocol_r == '0;
    ctl.rclamp = ocol_r == w_m1;
    ctl.tclamp = orow_r == '0;
    ctl.bclamp = orow_r == h_m1;
  end

  // Configuration and raster counters.
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    lead_nxt   = lead_r;
    ocol_nxt   = ocol_r;
    orow_nxt   = orow_r;
    if (cfg_wr) begin
      unique case (cfg_index)
        abmx_pkg::REG_IMAGE_WIDTH: begin
          width_nxt = cfg_data[abmx_pkg::WID_W-1:0];
        end
        abmx_pkg::REG_IMAGE_HEIGHT: begin
          height_nxt = cfg_data[abmx_pkg::ROW_W-1:0];
        end
      endcase
      col_nxt  = '0;
      row_nxt  = '0;
      lead_nxt = '0;
      ocol_nxt = '0;
      orow_nxt = '0;
    end else if (step) begin
      if (col_r == w_m1) begin
        col_nxt = '0;
        if (feeding) begin
          row_nxt = row_r + abmx_pkg::ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + abmx_pkg::COL_W'(1);
      end
      if (!emit) begin
        lead_nxt = lead_r + abmx_pkg::WID_W'(1);
      end else if (ctl.rclamp && ctl.bclamp) begin
        // Final result of the frame: start over.
        col_nxt  = '0;
        row_nxt  = '0;
        lead_nxt = '0;
        ocol_nxt = '0;
        orow_nxt = '0;
      end else if (ctl.rclamp) begin
        ocol_nxt = '0;
        orow_nxt = orow_r + abmx_pkg::ROW_W'(1);
      end else begin
        ocol_nxt = ocol_r + abmx_pkg::COL_W'(1);
      end
    end
  end

  abmx_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .step      (step),
    .step_ctl  (ctl),
    .step_pix  (in_data.pixel_value),
    .win_valid (win_valid),
    .win       (win),
    .win_last  (win_last)
  );

  abmx_pick u_pick (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .win_valid (win_valid),
    .win       (win),
    .win_last  (win_last),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register with one skid word behind it.
  assign push     = adv && res_valid;
  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    skid_valid_nxt = skid_valid_r;
    skid_word_nxt  = skid_word_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_word_nxt   = skid_word_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_word_nxt  = res;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= abmx_pkg::WIDTH_RESET;
      height_r     <= abmx_pkg::HEIGHT_RESET;
      col_r        <= '0;
      row_r        <= '0;
      lead_r       <= '0;
      ocol_r       <= '0;
      orow_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      lead_r       <= lead_nxt;
      ocol_r       <= ocol_nxt;
      orow_r       <= orow_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the 3x3 absolute-maximum window filter.
// Drives raster frames with random idling on both channels and checks every result
// against a predictor held here; depends on abmx_pkg and abs_max_window_filter_3x3.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RING_DEPTH  = 4096;
  localparam int RAND_WORDS  = 300;
  localparam int QUIET_FROM  = 250;
  localparam int WIDE_WORDS  = 128;
  localparam int TALL_WORDS  = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_valid = 1'b0;
  logic                            in_stall;
  abmx_pkg::in_word_t              in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  abmx_pkg::out_word_t             out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [abmx_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [abmx_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Words waiting to be sent, and filtered pixels still owed by the block.
  abmx_pkg::in_word_t  pending[$];
  abmx_pkg::out_word_t filtered_due[$];
  int unsigned words_queued = 0;
  int unsigned words_taken = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;

  // Idling state of the sender and the receiver.
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned recv_gap = 0;
  int unsigned recv_calm = 0;
  abmx_pkg::out_word_t want;

  // Predictor state: registers, pixel history by raster index, and frame counters.
  logic [abmx_pkg::WID_W-1:0] width_reg = abmx_pkg::WIDTH_RESET;
  logic [abmx_pkg::ROW_W-1:0] height_reg = abmx_pkg::HEIGHT_RESET;
  abmx_pkg::pix_t             pix_ring [RING_DEPTH];
  int unsigned                fed_cnt = 0;
  int unsigned                lead_cnt = 0;
  int unsigned                out_cnt = 0;

  abs_max_window_filter_3x3 i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > abmx_pkg::MAX_WIDTH) return abmx_pkg::MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_h();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic void restart_frame();
    fed_cnt = 0;
    lead_cnt = 0;
    out_cnt = 0;
  endfunction

  // The most negative pixel must compare as 32768, so work in int.
  function automatic int magnitude(abmx_pkg::pix_t v);
    return (v < 0) ? -int'(v) : int'(v);
  endfunction

  // Works out the filtered pixel, if any, that one accepted word causes.
  function automatic void filter_word(abmx_pkg::in_word_t word);
    int unsigned w, h, total, orow, ocol;
    int rr, cc;
    abmx_pkg::pix_t best, cand;
    abmx_pkg::out_word_t res;
    w = eff_w();
    h = eff_h();
    total = w * h;
    // While pixels are still expected a flush word is dropped; afterwards every
    // word, pixel or not, only drains.
    if (fed_cnt < total) begin
      if (word.flush) return;
      pix_ring[fed_cnt % RING_DEPTH] = word.pixel_value;
      fed_cnt++;
    end
    if (lead_cnt < w + 1) begin
      lead_cnt++;
      return;
    end
    orow = out_cnt / w;
    ocol = out_cnt % w;
    best = pix_ring[out_cnt % RING_DEPTH];
    // Scan top row first, left to right; only a strictly larger magnitude wins.
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = int'(orow) + dr;
        cc = int'(ocol) + dc;
        if (rr < 0) rr = 0;
        if (rr > int'(h) - 1) rr = int'(h) - 1;
        if (cc < 0) cc = 0;
        if (cc > int'(w) - 1) cc = int'(w) - 1;
        cand = pix_ring[(rr * int'(w) + cc) % RING_DEPTH];
        if (magnitude(cand) > magnitude(best)) best = cand;
      end
    end
    res.filtered_pixel = best;
    res.frame_last = (out_cnt + 1 == total);
    filtered_due.push_back(res);
    out_cnt++;
    if (out_cnt >= total) restart_frame();
  endfunction

  function automatic void queue_word(logic flush, abmx_pkg::pix_t px);
    abmx_pkg::in_word_t wd;
    wd.flush = flush;
    wd.pixel_value = px;
    pending.push_back(wd);
    words_queued++;
  endfunction

  // Pixels biased towards the extremes and towards equal magnitudes of both signs.
  function automatic abmx_pkg::pix_t rand_pixel();
    case ($urandom_range(0, 9))
      0: return abmx_pkg::pix_t'(-32768);
      1: return abmx_pkg::pix_t'(32767);
      2: return abmx_pkg::pix_t'(-32767);
      3: return abmx_pkg::pix_t'(0);
      4, 5: return abmx_pkg::pix_t'(($urandom_range(0, 1) ? 1 : -1) *
                                     int'($urandom_range(2, 3)));
      default: return abmx_pkg::pix_t'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic write_reg(input logic [abmx_pkg::CFG_IDX_W-1:0] idx,
                           input logic [abmx_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == abmx_pkg::REG_IMAGE_WIDTH) width_reg = val[abmx_pkg::WID_W-1:0];
    else height_reg = val;
    restart_frame();
    cfg_valid <= 1'b0;
  endtask

  // Block is idle once every word is taken, nothing is owed and the pipeline has drained.
  task automatic wait_idle();
    while (words_taken != words_queued || filtered_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Input driver: counts and predicts accepted words, then presents the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        filter_word(in_data);
        words_taken++;
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending.size() != 0 && !quiet && send_calm == 0 &&
                   $urandom_range(0, 6) == 0) begin
        send_gap = $urandom_range(1, 13) - 1;
        send_calm = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : 0;
        in_valid <= 1'b0;
      end else if (pending.size() != 0) begin
        in_data <= pending.pop_front();
        in_valid <= 1'b1;
        if (send_calm > 0) send_calm--;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: compares each accepted word with the oldest owed one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (filtered_due.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual pixel %0d last %0b",
                   $time, out_data.filtered_pixel, out_data.frame_last);
          errors++;
        end else begin
          want = filtered_due.pop_front();
          if (out_data.filtered_pixel !== want.filtered_pixel) begin
            $display("%0t: filtered_pixel mismatch: expected %0d, actual %0d",
                     $time, want.filtered_pixel, out_data.filtered_pixel);
            errors++;
          end
          if (out_data.frame_last !== want.frame_last) begin
            $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                     $time, want.frame_last, out_data.frame_last);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && recv_calm == 0 && $urandom_range(0, 6) == 0) begin
        recv_gap = $urandom_range(1, 13) - 1;
        recv_calm = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : 0;
        out_stall <= 1'b1;
      end else begin
        if (recv_calm > 0) recv_calm--;
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [abmx_pkg::CFG_DATA_W-1:0] wraw, hraw;
    int unsigned npix, nfr, cut, rand_words;
    bit broken;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3x3 frame: extremes, a centre tie, a stray flush and a pixel word while draining.
    write_reg(abmx_pkg::REG_IMAGE_WIDTH, 16'd3);
    write_reg(abmx_pkg::REG_IMAGE_HEIGHT, 16'd3);
    queue_word(1'b0, abmx_pkg::pix_t'(100));
    queue_word(1'b0, abmx_pkg::pix_t'(-100));
    queue_word(1'b1, abmx_pkg::pix_t'(-1));
    queue_word(1'b0, abmx_pkg::pix_t'(7));
    queue_word(1'b0, abmx_pkg::pix_t'(-32768));
    queue_word(1'b0, abmx_pkg::pix_t'(32767));
    queue_word(1'b0, abmx_pkg::pix_t'(-32767));
    queue_word(1'b0, abmx_pkg::pix_t'(0));
    queue_word(1'b0, abmx_pkg::pix_t'(-1));
    queue_word(1'b0, abmx_pkg::pix_t'(1));
    queue_word(1'b1, abmx_pkg::pix_t'(0));
    queue_word(1'b0, abmx_pkg::pix_t'(1234));
    queue_word(1'b1, abmx_pkg::pix_t'(32767));
    queue_word(1'b1, abmx_pkg::pix_t'(-32768));
    wait_idle();

    // Zero width and height both act as one, with a flush at the start of the frame.
    write_reg(abmx_pkg::REG_IMAGE_WIDTH, 16'd0);
    write_reg(abmx_pkg::REG_IMAGE_HEIGHT, 16'd0);
    queue_word(1'b1, abmx_pkg::pix_t'(5));
    queue_word(1'b0, abmx_pkg::pix_t'(-32768));
    queue_word(1'b0, abmx_pkg::pix_t'(32767));
    queue_word(1'b1, abmx_pkg::pix_t'(-2));
    wait_idle();

    // Widest image, written with every data bit set so the width saturates; only the
    // opening pixels are sent, too few for any result.
    write_reg(abmx_pkg::REG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(abmx_pkg::REG_IMAGE_HEIGHT, 16'd2);
    for (int p = 0; p < WIDE_WORDS; p++) queue_word(1'b0, rand_pixel());
    wait_idle();

    // Tallest image, one column wide; only its opening rows are sent.
    write_reg(abmx_pkg::REG_IMAGE_WIDTH, 16'd1);
    write_reg(abmx_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
    for (int p = 0; p < TALL_WORDS; p++) queue_word(1'b0, rand_pixel());
    wait_idle();

    // Random frames, mostly complete and drained, some cut short by a register write.
    rand_words = 0;
    while (rand_words < RAND_WORDS) begin
      if (rand_words >= QUIET_FROM) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0: wraw = abmx_pkg::CFG_DATA_W'($urandom_range(0, 1));
        1, 2: wraw = abmx_pkg::CFG_DATA_W'($urandom_range(7, 40));
        default: wraw = abmx_pkg::CFG_DATA_W'($urandom_range(2, 6));
      endcase
      hraw = abmx_pkg::CFG_DATA_W'($urandom_range(0, 6));
      if ($urandom_range(0, 1)) begin
        write_reg(abmx_pkg::REG_IMAGE_WIDTH, wraw);
        write_reg(abmx_pkg::REG_IMAGE_HEIGHT, hraw);
      end else begin
        write_reg(abmx_pkg::REG_IMAGE_HEIGHT, hraw);
        write_reg(abmx_pkg::REG_IMAGE_WIDTH, wraw);
      end
      nfr = $urandom_range(1, 3);
      for (int f = 0; f < nfr; f++) begin
        npix = eff_w() * eff_h();
        broken = ($urandom_range(0, 7) == 0);
        cut = broken ? $urandom_range(0, npix - 1) : npix;
        for (int p = 0; p < cut; p++) begin
          if ($urandom_range(0, 11) == 0) queue_word(1'b1, rand_pixel());
          queue_word(1'b0, rand_pixel());
        end
        rand_words += cut;
        if (broken) break;
        for (int p = 0; p <= eff_w(); p++) queue_word($urandom_range(0, 4) != 0, rand_pixel());
        if ($urandom_range(0, 5) == 0) queue_word(1'b1, rand_pixel());
      end
      wait_idle();
    end

    quiet = 1'b1;
    wait_idle();
    repeat (10) @(posedge clk);
    if (filtered_due.size() != 0) begin
      $display("%0t: results outstanding: expected 0, actual %0d",
               $time, filtered_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/abmx_pkg.sv
sv/abmx_window.sv
sv/abmx_pick.sv
sv/abs_max_window_filter_3x3.sv
dv/tb_top.sv
